@@ rtl/core/svpwm_pkg.sv @@
// Shared types and fixed-point constants for the seven-segment SVPWM compare core.
// No dependencies. The core modules and the bench import it.
package svpwm_pkg;

    // Sector code from the projection signs: bit0 u1 > 0, bit1 u2 > 0, bit2 u3 > 0
    typedef enum logic [2:0] {
        SEC_ZERO = 3'd0,
        SEC_P1   = 3'd1,
        SEC_P2   = 3'd2,
        SEC_P12  = 3'd3,
        SEC_P3   = 3'd4,
        SEC_P13  = 3'd5,
        SEC_P23  = 3'd6,
        SEC_ALL  = 3'd7
    } t_sector;

    localparam int CFG_W      = 16;               // carrier_period write data
    localparam int CFG_EXT_W  = 32;               // widest kept period
    localparam int CMP_W      = 16;               // compare outputs
    localparam int CMP_EXT_W  = CFG_EXT_W + 1;    // compare before saturation
    localparam logic [CMP_W-1:0] CMP_MAX = 16'hFFFF;

    localparam int VQ_W       = 32;               // references in Q30
    localparam int SQRT3_W    = 25;
    localparam logic [SQRT3_W-1:0] SQRT3_Q24 = 25'd29058991;
    localparam int SQRT3_FRAC = 24;
    localparam int NUM_W      = 58;               // Q55 projection numerators
    localparam int PROJ_SH    = 25;               // Q55 -> Q30
    localparam int U_W        = NUM_W - PROJ_SH;  // signed Q30 projections
    localparam int TIME_W     = U_W - 1;          // clamped active times
    localparam int SUM_W      = TIME_W + 1;       // sum of two active times
    localparam int REM_W      = SUM_W + 1;        // divider partial remainder

    localparam int Q_W        = 31;               // times and duties, at most 2^30
    localparam int QS_W       = Q_W + 1;
    localparam int DUTY_FRAC  = 30;
    localparam logic [Q_W-1:0] ONE_Q30  = 31'h4000_0000;
    localparam logic [Q_W-1:0] HALF_Q30 = 31'h2000_0000;

    // projection pipe -> divider
    typedef struct packed {
        t_sector             sector;
        logic                ovm;
        logic [TIME_W-1:0]   tf;
        logic [TIME_W-1:0]   ts;
        logic [SUM_W-1:0]    sum;
    } t_div_in;

    // divider -> duty / compare pipe
    typedef struct packed {
        t_sector             sector;
        logic [Q_W-1:0]      t_first;
        logic [Q_W-1:0]      t_second;
    } t_duty_in;

    // compare pipe -> output register
    typedef struct packed {
        t_sector             sector;
        logic [CMP_W-1:0]    cmp_a;
        logic [CMP_W-1:0]    cmp_b;
        logic [CMP_W-1:0]    cmp_c;
    } t_cmp_word;

endpackage

@@ rtl/core/svpwm_in_if.sv @@
// Input channel: one alpha-beta reference pair per word, valid/ready handshake.
// Width follows IN_WIDTH; no package dependency.
interface svpwm_in_if #(
    parameter int IN_WIDTH = 16
) ();
    logic                       valid;
    logic                       ready;
    logic signed [IN_WIDTH-1:0] v_alpha;
    logic signed [IN_WIDTH-1:0] v_beta;

    modport source (output valid, output v_alpha, output v_beta, input ready);
    modport sink   (input valid, input v_alpha, input v_beta, output ready);
endinterface

@@ rtl/core/svpwm_out_if.sv @@
// Output channel: sector code and three phase compare values per word.
// Valid/ready handshake; no package dependency.
interface svpwm_out_if ();
    logic        valid;
    logic        ready;
    logic [2:0]  sector_code;
    logic [15:0] compare_a;
    logic [15:0] compare_b;
    logic [15:0] compare_c;

    modport source (output valid, output sector_code, output compare_a,
                    output compare_b, output compare_c, input ready);
    modport sink   (input valid, input sector_code, input compare_a,
                    input compare_b, input compare_c, output ready);
endinterface

@@ rtl/core/svpwm_proj.sv @@
// Projection front end: sqrt3 multiply, Q55 numerators, sector code, active time pick.
// Four register stages. Depends on svpwm_pkg.
module svpwm_proj #(
    parameter int IN_WIDTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic signed [IN_WIDTH-1:0] i_v_alpha,
    input  logic signed [IN_WIDTH-1:0] i_v_beta,
    output logic                       o_vld,
    output svpwm_pkg::t_div_in         o_word
);
    import svpwm_pkg::*;

    logic signed [VQ_W-1:0]  w_va;
    logic signed [VQ_W-1:0]  w_vb;
    logic signed [NUM_W-1:0] w_prod;
    logic signed [NUM_W-1:0] w_vb_sh;
    logic signed [NUM_W-1:0] w_n2;
    logic signed [NUM_W-1:0] w_n3;
    logic [2:0]              w_sign;
    logic signed [U_W-1:0]   w_f;
    logic signed [U_W-1:0]   w_s;
    logic [SUM_W-1:0]        w_sum;

    logic                    r1_vld;
    logic signed [NUM_W-1:0] r1_prod;
    logic signed [VQ_W-1:0]  r1_vb;
    logic                    r2_vld;
    t_sector                 r2_sec;
    logic signed [U_W-1:0]   r2_u1;
    logic signed [U_W-1:0]   r2_u2;
    logic signed [U_W-1:0]   r2_u3;
    logic                    r3_vld;
    t_sector                 r3_sec;
    logic [TIME_W-1:0]       r3_tf;
    logic [TIME_W-1:0]       r3_ts;
    logic                    r4_vld;
    t_div_in                 r4_word;

    // stage 1: scale to Q30, alpha * sqrt3
    assign w_va   = VQ_W'(i_v_alpha) <<< (VQ_W - IN_WIDTH);
    assign w_vb   = VQ_W'(i_v_beta) <<< (VQ_W - IN_WIDTH);
    assign w_prod = w_va * $signed({1'b0, SQRT3_Q24});

    // stage 2: exact numerators, signs taken before the floor shift
    assign w_vb_sh = NUM_W'(r1_vb) <<< SQRT3_FRAC;
    assign w_n2    = r1_prod - w_vb_sh;
    assign w_n3    = -r1_prod - w_vb_sh;
    assign w_sign  = {!w_n3[NUM_W-1] && (w_n3 != '0),
                      !w_n2[NUM_W-1] && (w_n2 != '0),
                      !r1_vb[VQ_W-1] && (r1_vb != '0)};

    // stage 3: active times for the sector
    always_comb begin
        case (r2_sec)
            SEC_P1: begin
                w_f = -r2_u2;
                w_s = -r2_u3;
            end
            SEC_P2: begin
                w_f = -r2_u3;
                w_s = -r2_u1;
            end
            SEC_P12: begin
                w_f = r2_u2;
                w_s = r2_u1;
            end
            SEC_P3: begin
                w_f = -r2_u1;
                w_s = -r2_u2;
            end
            SEC_P13: begin
                w_f = r2_u1;
                w_s = r2_u3;
            end
            SEC_P23: begin
                w_f = r2_u3;
                w_s = r2_u2;
            end
            default: begin
                w_f = '0;
                w_s = '0;
            end
        endcase
    end

    // stage 4: sum and overmodulation flag
    assign w_sum = SUM_W'(r3_tf) + SUM_W'(r3_ts);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_prod <= w_prod;
            r1_vb   <= w_vb;
            r2_sec  <= t_sector'(w_sign);
            r2_u1   <= U_W'(r1_vb);
            r2_u2   <= w_n2[NUM_W-1:PROJ_SH];
            r2_u3   <= w_n3[NUM_W-1:PROJ_SH];
            r3_sec  <= r2_sec;
            r3_tf   <= w_f[U_W-1] ? '0 : w_f[TIME_W-1:0];
            r3_ts   <= w_s[U_W-1] ? '0 : w_s[TIME_W-1:0];
            r4_word.sector <= r3_sec;
            r4_word.ovm    <= w_sum > SUM_W'(ONE_Q30);
            r4_word.tf     <= r3_tf;
            r4_word.ts     <= r3_ts;
            r4_word.sum    <= w_sum;
        end
    end

    assign o_vld  = r4_vld;
    assign o_word = r4_word;

endmodule

@@ rtl/core/svpwm_div.sv @@
// Pipelined restoring divider for overmodulation: t * 2^30 / sum for both active times.
// One quotient bit per stage, Q_W stages. Depends on svpwm_pkg.
module svpwm_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  svpwm_pkg::t_div_in   i_word,
    output logic                 o_vld,
    output svpwm_pkg::t_duty_in  o_word
);
    import svpwm_pkg::*;

    logic             w_in_vld   [Q_W];
    t_div_in          w_in_word  [Q_W];
    logic [REM_W-1:0] w_tri_f    [Q_W];
    logic [REM_W-1:0] w_tri_s    [Q_W];
    logic [Q_W-1:0]   w_in_q_f   [Q_W];
    logic [Q_W-1:0]   w_in_q_s   [Q_W];
    logic             w_ge_f     [Q_W];
    logic             w_ge_s     [Q_W];
    logic [REM_W-1:0] w_div      [Q_W];

    logic             r_vld      [Q_W];
    t_div_in          r_word     [Q_W];
    logic [REM_W-1:0] r_rem_f    [Q_W];
    logic [REM_W-1:0] r_rem_s    [Q_W];
    logic [Q_W-1:0]   r_q_f      [Q_W];
    logic [Q_W-1:0]   r_q_s      [Q_W];

    // first stage takes the time as is (t <= sum), later stages shift the remainder
    always_comb begin
        w_in_vld[0]  = i_vld;
        w_in_word[0] = i_word;
        w_tri_f[0]   = REM_W'(i_word.tf);
        w_tri_s[0]   = REM_W'(i_word.ts);
        w_in_q_f[0]  = '0;
        w_in_q_s[0]  = '0;
        for (int j = 1; j < Q_W; j++) begin
            w_in_vld[j]  = r_vld[j-1];
            w_in_word[j] = r_word[j-1];
            w_tri_f[j]   = {r_rem_f[j-1][REM_W-2:0], 1'b0};
            w_tri_s[j]   = {r_rem_s[j-1][REM_W-2:0], 1'b0};
            w_in_q_f[j]  = r_q_f[j-1];
            w_in_q_s[j]  = r_q_s[j-1];
        end
        for (int j = 0; j < Q_W; j++) begin
            w_div[j]  = REM_W'(w_in_word[j].sum);
            w_ge_f[j] = w_tri_f[j] >= w_div[j];
            w_ge_s[j] = w_tri_s[j] >= w_div[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < Q_W; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else if (i_en) begin
            for (int j = 0; j < Q_W; j++) begin
                r_vld[j] <= w_in_vld[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < Q_W; j++) begin
                r_word[j]  <= w_in_word[j];
                r_rem_f[j] <= w_ge_f[j] ? w_tri_f[j] - w_div[j] : w_tri_f[j];
                r_rem_s[j] <= w_ge_s[j] ? w_tri_s[j] - w_div[j] : w_tri_s[j];
                r_q_f[j]   <= {w_in_q_f[j][Q_W-2:0], w_ge_f[j]};
                r_q_s[j]   <= {w_in_q_s[j][Q_W-2:0], w_ge_s[j]};
            end
        end
    end

    // without overmodulation the sum is at most 2^30, so the raw times fit Q_W bits
    assign o_vld           = r_vld[Q_W-1];
    assign o_word.sector   = r_word[Q_W-1].sector;
    assign o_word.t_first  = r_word[Q_W-1].ovm ? r_q_f[Q_W-1] : r_word[Q_W-1].tf[Q_W-1:0];
    assign o_word.t_second = r_word[Q_W-1].ovm ? r_q_s[Q_W-1] : r_word[Q_W-1].ts[Q_W-1:0];

endmodule

@@ rtl/core/svpwm_cmp.sv @@
// Seven-segment duty build and compare scaling: (duty + 1/2) * period, saturated.
// Four register stages; the saturate step feeds the output register. Depends on svpwm_pkg.
module svpwm_cmp #(
    parameter int PERIOD_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic [PERIOD_WIDTH-1:0] i_period,
    input  logic                    i_vld,
    input  svpwm_pkg::t_duty_in     i_word,
    output logic                    o_vld,
    output svpwm_pkg::t_cmp_word    o_word
);
    import svpwm_pkg::*;

    localparam int MUL_W = Q_W + PERIOD_WIDTH;

    logic [QS_W-1:0]   w_sum;
    logic [Q_W-1:0]    w_lo;
    logic [Q_W-1:0]    w_mid;
    logic [Q_W-1:0]    w_hi;
    logic [Q_W-1:0]    w_duty [3];

    logic              r1_vld;
    t_sector           r1_sec;
    logic [Q_W-1:0]    r1_tf;
    logic [Q_W-1:0]    r1_ts;
    logic [Q_W-1:0]    r1_sum;
    logic              r2_vld;
    t_sector           r2_sec;
    logic [Q_W-1:0]    r2_lo;
    logic [Q_W-1:0]    r2_mid;
    logic [Q_W-1:0]    r2_ts;
    logic              r3_vld;
    t_sector           r3_sec;
    logic [Q_W-1:0]    r3_d   [3];
    logic              r4_vld;
    t_sector           r4_sec;
    logic [MUL_W-1:0]  r4_p   [3];

    function automatic logic [CMP_W-1:0] sat_cmp(input logic [CMP_EXT_W-1:0] v);
        return (v > CMP_EXT_W'(CMP_MAX)) ? CMP_MAX : v[CMP_W-1:0];
    endfunction

    // stage 1: total active time, never above one
    assign w_sum = QS_W'(i_word.t_first) + QS_W'(i_word.t_second);

    // stage 2: zero-vector quarter and middle edge
    assign w_lo  = (ONE_Q30 - r1_sum) >> 2;
    assign w_mid = w_lo + (r1_tf >> 1);

    // stage 3: top edge and phase placement per sector
    assign w_hi = r2_mid + (r2_ts >> 1);

    always_comb begin
        case (r2_sec)
            SEC_P1: begin
                w_duty[0] = r2_mid;
                w_duty[1] = r2_lo;
                w_duty[2] = w_hi;
            end
            SEC_P2: begin
                w_duty[0] = r2_lo;
                w_duty[1] = w_hi;
                w_duty[2] = r2_mid;
            end
            SEC_P12: begin
                w_duty[0] = r2_lo;
                w_duty[1] = r2_mid;
                w_duty[2] = w_hi;
            end
            SEC_P3: begin
                w_duty[0] = w_hi;
                w_duty[1] = r2_mid;
                w_duty[2] = r2_lo;
            end
            SEC_P13: begin
                w_duty[0] = w_hi;
                w_duty[1] = r2_lo;
                w_duty[2] = r2_mid;
            end
            SEC_P23: begin
                w_duty[0] = r2_mid;
                w_duty[1] = w_hi;
                w_duty[2] = r2_lo;
            end
            default: begin
                // zero vectors: half duty on every phase
                w_duty[0] = HALF_Q30;
                w_duty[1] = HALF_Q30;
                w_duty[2] = HALF_Q30;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sec <= i_word.sector;
            r1_tf  <= i_word.t_first;
            r1_ts  <= i_word.t_second;
            r1_sum <= (w_sum > QS_W'(ONE_Q30)) ? ONE_Q30 : w_sum[Q_W-1:0];
            r2_sec <= r1_sec;
            r2_lo  <= w_lo;
            r2_mid <= w_mid;
            r2_ts  <= r1_ts;
            r3_sec <= r2_sec;
            r4_sec <= r3_sec;
            for (int k = 0; k < 3; k++) begin
                r3_d[k] <= w_duty[k] + HALF_Q30;
                r4_p[k] <= MUL_W'(r3_d[k]) * MUL_W'(i_period);
            end
        end
    end

    assign o_vld         = r4_vld;
    assign o_word.sector = r4_sec;
    assign o_word.cmp_a  = sat_cmp(CMP_EXT_W'(r4_p[0][MUL_W-1:DUTY_FRAC]));
    assign o_word.cmp_b  = sat_cmp(CMP_EXT_W'(r4_p[1][MUL_W-1:DUTY_FRAC]));
    assign o_word.cmp_c  = sat_cmp(CMP_EXT_W'(r4_p[2][MUL_W-1:DUTY_FRAC]));

endmodule

@@ rtl/core/svpwm_seven_segment_compare_core.sv @@
// Seven-segment SVPWM compare core, top level: config register, pipeline, output skid.
// Depends on svpwm_pkg, svpwm_in_if, svpwm_out_if, svpwm_proj, svpwm_div, svpwm_cmp.
//
// Usage:
//   i_in carries one alpha-beta reference word (signed Q2.(IN_WIDTH-2)) per handshake;
//   o_out returns one word per input: sector code and three phase compare values.
//   i_cfg_we / i_cfg_wdata load carrier_period (low PERIOD_WIDTH bits kept); write it
//   only while no word is in flight.
// Timing:
//   Throughput is one word per clock while the skid register is empty. Each word passes from
//   the accepting edge to o_out.valid through 4 projection stages, 31 divider stages (one
//   quotient bit each), 4 duty and compare stages, and the output register.
// Reset:
//   i_rst_n is synchronous, active low; it empties every stage, the output register and
//   the skid register, and clears carrier_period to zero.
// Backpressure:
//   When o_out.ready is low the output holds its word and the pipeline keeps moving
//   until the next finished word lands in the skid register; only then does i_in.ready
//   drop and the whole pipeline freeze. Nothing is dropped or repeated.
module svpwm_seven_segment_compare_core #(
    parameter int IN_WIDTH     = 16,
    parameter int PERIOD_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [svpwm_pkg::CFG_W-1:0] i_cfg_wdata,
    svpwm_in_if.sink                    i_in,
    svpwm_out_if.source                 o_out
);
    import svpwm_pkg::*;

    logic [CFG_EXT_W-1:0]    w_cfg_ext;
    logic [PERIOD_WIDTH-1:0] r_period;

    logic                    w_en;
    logic                    w_proj_vld;
    t_div_in                 w_proj_word;
    logic                    w_div_vld;
    t_duty_in                w_div_word;
    logic                    w_cmp_vld;
    t_cmp_word               w_cmp_word;
    logic                    w_take;

    logic                    r_out_vld;
    t_cmp_word               r_out;
    logic                    r_skid_vld;
    t_cmp_word               r_skid;
    logic                    n_out_vld;
    t_cmp_word               n_out;
    logic                    n_skid_vld;
    t_cmp_word               n_skid;

    assign w_cfg_ext = CFG_EXT_W'(i_cfg_wdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= '0;
        end else if (i_cfg_we) begin
            r_period <= w_cfg_ext[PERIOD_WIDTH-1:0];
        end
    end

    // pipeline freezes only once the skid register holds a word
    assign w_en       = !r_skid_vld;
    assign i_in.ready = w_en;

    svpwm_proj #(
        .IN_WIDTH (IN_WIDTH)
    ) u_proj (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_vld     (i_in.valid),
        .i_v_alpha (i_in.v_alpha),
        .i_v_beta  (i_in.v_beta),
        .o_vld     (w_proj_vld),
        .o_word    (w_proj_word)
    );

    svpwm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_proj_vld),
        .i_word  (w_proj_word),
        .o_vld   (w_div_vld),
        .o_word  (w_div_word)
    );

    svpwm_cmp #(
        .PERIOD_WIDTH (PERIOD_WIDTH)
    ) u_cmp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_period (r_period),
        .i_vld    (w_div_vld),
        .i_word   (w_div_word),
        .o_vld    (w_cmp_vld),
        .o_word   (w_cmp_word)
    );

    assign w_take = r_out_vld && o_out.ready;

    always_comb begin
        n_out_vld  = r_out_vld;
        n_out      = r_out;
        n_skid_vld = r_skid_vld;
        n_skid     = r_skid;
        if (w_take) begin
            n_out_vld = 1'b0;
        end
        if (r_skid_vld) begin
            if (w_take) begin
                n_out_vld  = 1'b1;
                n_out      = r_skid;
                n_skid_vld = 1'b0;
            end
        end else if (w_cmp_vld) begin
            if (!r_out_vld || w_take) begin
                n_out_vld = 1'b1;
                n_out     = w_cmp_word;
            end else begin
                n_skid_vld = 1'b1;
                n_skid     = w_cmp_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.sector_code = r_out.sector;
    assign o_out.compare_a   = r_out.cmp_a;
    assign o_out.compare_b   = r_out.cmp_b;
    assign o_out.compare_c   = r_out.cmp_c;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid word held with output register empty");

    a_no_all_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.sector_code != SEC_ALL))
        else $error("all three projections positive, sign logic broken");

    a_skid_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && !o_out.ready) |=> (r_skid_vld && $stable(r_skid)))
        else $error("skid word lost or changed while output stalled");
`endif

endmodule

@@ test/tb_top.sv @@
// Self-checking bench for svpwm_seven_segment_compare_core: directed and random
// alpha-beta words against a built-in fixed-point SVPWM predictor, across several
// carrier periods. Depends on svpwm_pkg, svpwm_in_if, svpwm_out_if and the core RTL.
`timescale 1ns / 100ps

module tb_top;
    import svpwm_pkg::*;

    localparam int IN_W             = 16;
    localparam int RANDOM_PER_PHASE = 140;
    localparam int HOLD_CYCLES      = 300;
    localparam int DRAIN_CYCLES     = 60;
    localparam longint unsigned UNIT = ONE_Q30;
    localparam longint unsigned HALF = HALF_Q30;
    localparam longint unsigned CLAMP = CMP_MAX;

    typedef struct packed {
        logic signed [IN_W-1:0] alpha;
        logic signed [IN_W-1:0] beta;
    } ab_pair_t;

    typedef struct {
        t_sector                sector;
        logic [CMP_W-1:0]       cmp_a;
        logic [CMP_W-1:0]       cmp_b;
        logic [CMP_W-1:0]       cmp_c;
        logic signed [IN_W-1:0] alpha;
        logic signed [IN_W-1:0] beta;
        bit                     ovm;
    } compare_word_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_EVERY4, RX_MOSTLY} rx_mode_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_W-1:0]  i_cfg_wdata;

    svpwm_in_if #(.IN_WIDTH(IN_W)) in_ch ();
    svpwm_out_if                   out_ch ();

    svpwm_seven_segment_compare_core #(
        .IN_WIDTH     (IN_W),
        .PERIOD_WIDTH (16)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always #1 i_clk = ~i_clk;

    ab_pair_t         pending_pairs[$];
    compare_word_t    expected_words[$];
    logic [CFG_W-1:0] carrier_period_q = '0;
    bit               sender_paused = 1'b0;
    int               hold_requests = 0;
    int               hold_served = 0;
    int               mismatches = 0;
    int               items_accepted = 0;
    int               results_checked = 0;
    int               ovm_hits = 0;
    int               sector_hits[8];
    int               periods_used = 0;

    // Seven-segment duties for one alpha-beta pair, then compares at the given period.
    function automatic compare_word_t predict_compares(logic signed [IN_W-1:0] alpha,
                                                       logic signed [IN_W-1:0] beta,
                                                       logic [CFG_W-1:0] period);
        longint          va, vb, n2, n3, u1, u2, u3, f, s, sq3, b24;
        longint unsigned tf, ts, sum, cmp;
        longint unsigned duty[3];
        int              lo, mid, hi;
        compare_word_t   w;
        sq3 = longint'(SQRT3_Q24);
        b24 = longint'(1) << SQRT3_FRAC;
        va  = longint'(alpha) * (longint'(1) << (32 - IN_W));
        vb  = longint'(beta) * (longint'(1) << (32 - IN_W));
        n2  = va * sq3 - vb * b24;
        n3  = -va * sq3 - vb * b24;
        u1  = vb;
        u2  = n2 >>> PROJ_SH;
        u3  = n3 >>> PROJ_SH;
        w.sector = t_sector'({n3 > 0, n2 > 0, vb > 0});
        w.alpha  = alpha;
        w.beta   = beta;
        w.ovm    = 1'b0;
        f = 0; s = 0; lo = -1; mid = 0; hi = 0;
        case (w.sector)
            SEC_P1:  begin f = -u2; s = -u3; lo = 1; mid = 0; hi = 2; end
            SEC_P2:  begin f = -u3; s = -u1; lo = 0; mid = 2; hi = 1; end
            SEC_P12: begin f = u2;  s = u1;  lo = 0; mid = 1; hi = 2; end
            SEC_P3:  begin f = -u1; s = -u2; lo = 2; mid = 1; hi = 0; end
            SEC_P13: begin f = u1;  s = u3;  lo = 1; mid = 2; hi = 0; end
            SEC_P23: begin f = u3;  s = u2;  lo = 2; mid = 0; hi = 1; end
            default: lo = -1;
        endcase
        if (lo < 0) begin
            duty[0] = HALF;
            duty[1] = HALF;
            duty[2] = HALF;
        end else begin
            tf  = (f < 0) ? 64'd0 : longint'(f);
            ts  = (s < 0) ? 64'd0 : longint'(s);
            sum = tf + ts;
            if (sum > UNIT) begin
                w.ovm = 1'b1;
                tf = tf * UNIT / sum;
                ts = ts * UNIT / sum;
            end
            sum = tf + ts;
            if (sum > UNIT)
                sum = UNIT;
            duty[lo]  = (UNIT - sum) >> 2;
            duty[mid] = duty[lo] + (tf >> 1);
            duty[hi]  = duty[mid] + (ts >> 1);
        end
        for (int k = 0; k < 3; k++) begin
            cmp = ((duty[k] + HALF) * longint'(period)) >> DUTY_FRAC;
            if (cmp > CLAMP)
                cmp = CLAMP;
            duty[k] = cmp;
        end
        w.cmp_a = duty[0][CMP_W-1:0];
        w.cmp_b = duty[1][CMP_W-1:0];
        w.cmp_c = duty[2][CMP_W-1:0];
        return w;
    endfunction

    // Mix of full-range words, linear-region words and words near sector borders.
    function automatic ab_pair_t rand_pair();
        ab_pair_t p;
        int       a, b, kind;
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
            a = $urandom;
            b = $urandom;
        end else if (kind < 8) begin
            a = int'($urandom_range(0, 37838)) - 18919;
            b = int'($urandom_range(0, 37838)) - 18919;
        end else begin
            a = int'($urandom_range(0, 32768)) - 16384;
            case ($urandom_range(0, 2))
                0:       b = (a * 28378) / 16384;     // u2 sign line
                1:       b = -(a * 28378) / 16384;    // u3 sign line
                default: b = 0;                       // u1 sign line
            endcase
            b += int'($urandom_range(0, 6)) - 3;
        end
        p.alpha = a[IN_W-1:0];
        p.beta  = b[IN_W-1:0];
        return p;
    endfunction

    task automatic write_period(logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        carrier_period_q = value;
        periods_used++;
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_pairs.size() > 0 || expected_words.size() > 0 || in_ch.valid);
    endtask

    task automatic check_field(string field, longint unsigned want, longint unsigned got,
                               compare_word_t w);
        if (want != got) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d (alpha %0d, beta %0d)",
                     $time, field, want, got, w.alpha, w.beta);
        end
    endtask

    // Sender: bursts of random length with random gaps.
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin : drive_words
        bit taken;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            taken = in_ch.valid && in_ch.ready;
            if (taken) begin
                expected_words.push_back(predict_compares(pending_pairs[0].alpha,
                                                          pending_pairs[0].beta,
                                                          carrier_period_q));
                void'(pending_pairs.pop_front());
                items_accepted++;
            end
            if (!in_ch.valid || taken) begin
                if (burst_left == 0 && gap_left == 0) begin
                    burst_left = $urandom_range(1, 48);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                end
                if (gap_left > 0) begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end else if (pending_pairs.size() > 0 && !sender_paused) begin
                    burst_left--;
                    in_ch.valid   <= 1'b1;
                    in_ch.v_alpha <= pending_pairs[0].alpha;
                    in_ch.v_beta  <= pending_pairs[0].beta;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern switches every so often; a requested hold-off wins.
    int       hold_left = 0;
    int       mode_left = 0;
    int       rx_tick = 0;
    rx_mode_t rx_mode = RX_OPEN;

    always @(posedge i_clk) begin : drive_ready
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_left = 0;
            mode_left = 0;
        end else begin
            rx_tick++;
            if (hold_left == 0 && hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 160);
                end
                mode_left--;
                case (rx_mode)
                    RX_OPEN:   out_ch.ready <= 1'b1;
                    RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
                    RX_EVERY4: out_ch.ready <= (rx_tick % 4 == 0);
                    default:   out_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : check_words
        compare_word_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                $display("%0t ns: word with nothing expected, actual sector %0d cmp %0d %0d %0d",
                         $time, out_ch.sector_code, out_ch.compare_a, out_ch.compare_b,
                         out_ch.compare_c);
            end else begin
                want = expected_words.pop_front();
                check_field("sector_code", want.sector, out_ch.sector_code, want);
                check_field("compare_a", want.cmp_a, out_ch.compare_a, want);
                check_field("compare_b", want.cmp_b, out_ch.compare_b, want);
                check_field("compare_c", want.cmp_c, out_ch.compare_c, want);
                results_checked++;
                sector_hits[want.sector]++;
                if (want.ovm)
                    ovm_hits++;
            end
        end
    end

    initial begin : run_limit
        #400000;
        $display("svpwm_seven_segment_compare_core verification failed");
        $finish;
    end

    initial begin : run_phases
        ab_pair_t         directed[$];
        logic [CFG_W-1:0] period_plan[8];
        in_ch.valid   = 1'b0;
        in_ch.v_alpha = '0;
        in_ch.v_beta  = '0;
        out_ch.ready  = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        i_rst_n       = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extremes, axis steps, sector centers, sign-line crossings, overmodulation
        directed = '{'{0, 0}, '{32767, 32767}, '{-32768, -32768}, '{32767, -32768},
                     '{-32768, 32767}, '{32767, 0}, '{-32768, 0}, '{0, 32767},
                     '{0, -32768}, '{1, 0}, '{-1, 0}, '{0, 1}, '{0, -1},
                     '{7094, 4096}, '{0, 8192}, '{-7094, 4096}, '{-7094, -4096},
                     '{0, -8192}, '{7094, -4096}, '{4096, 7094}, '{4096, 7095},
                     '{-4096, 7094}, '{16384, 9459}, '{18919, 0}, '{-1, -1}};
        write_period(16'hFFFF);
        @(negedge i_clk);
        foreach (directed[k])
            pending_pairs.push_back(directed[k]);
        wait_idle();

        period_plan = '{16'd0, 16'd1, 16'd50001, 16'd32768, 16'd0, 16'd0, 16'hFFFF, 16'd255};
        period_plan[4] = 16'($urandom);
        period_plan[5] = 16'($urandom);
        for (int phase = 0; phase < 8; phase++) begin
            write_period(period_plan[phase]);
            @(negedge i_clk);
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                pending_pairs.push_back(rand_pair());
            if (phase == 2)
                hold_requests++;    // long receiver hold-off so the pipe backs up
            if (phase == 4) begin
                do @(negedge i_clk);
                while (pending_pairs.size() > RANDOM_PER_PHASE / 2);
                sender_paused = 1'b1;
                do @(negedge i_clk);
                while (expected_words.size() > 0 || in_ch.valid);
                sender_paused = 1'b0;
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Checked %0d results from %0d accepted words over %0d carrier periods.",
                 results_checked, items_accepted, periods_used);
        $display("Sector codes 0..6 seen %0d %0d %0d %0d %0d %0d %0d, overmodulated %0d.",
                 sector_hits[0], sector_hits[1], sector_hits[2], sector_hits[3],
                 sector_hits[4], sector_hits[5], sector_hits[6], ovm_hits);
        if (mismatches == 0) begin
            $display("svpwm_seven_segment_compare_core verification clean");
        end else begin
            $display("svpwm_seven_segment_compare_core verification failed");
        end
        $finish;
    end

endmodule
